>>> rtl/core/sesc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sesc_pkg;

   // Escape mode gives up when the expected length reaches this bound
   localparam int MAX_OUTPUT = 8192;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Measure mode count saturates here
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Control bytes sit below this code
   localparam logic [7:0] CTRL_LIMIT = 8'd32;

   localparam logic [7:0] ASCII_BACKSLASH = 8'h5C;

   // End-of-string status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CAPACITY = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   // Register indexes
   localparam logic REG_MEASURE_ONLY    = 1'b0;
   localparam logic REG_EXPECTED_LENGTH = 1'b1;

   // Encoded widths of one byte
   localparam logic [2:0] WIDTH_PLAIN = 3'd1;
   localparam logic [2:0] WIDTH_META  = 3'd2;
   localparam logic [2:0] WIDTH_CTRL  = 3'd4;

   typedef struct packed {
      logic        measure_only;
      logic [12:0] expected_length;
   } cfg_type;

   // One queued job: the words that a single input item causes
   typedef struct packed {
      logic [7:0]  byte_val;
      logic [2:0]  width;
      logic        emit;
      logic [1:0]  last_idx;
      logic [15:0] base;
      logic        last;
      logic [1:0]  status;
      logic [15:0] len;
      logic        esc;
   } job_type;

   // Classify one byte into its encoded width
   function automatic logic [2:0] byte_width(input logic [7:0] b);
      logic [2:0] w;
      if (b < CTRL_LIMIT) begin
         w = WIDTH_CTRL;
      end else begin
         case (b) inside
            8'h22, 8'h27, 8'h60, 8'h24, 8'h5C,
            8'h21, 8'h28, 8'h29, 8'h7C, 8'h20: w = WIDTH_META;
            default:                           w = WIDTH_PLAIN;
         endcase
      end
      return w;
   endfunction

   // Pick word i of the encoded sequence of byte b
   function automatic logic [7:0] seq_byte(input logic [7:0] b,
                                           input logic [2:0] w,
                                           input logic [1:0] i);
      logic [7:0] r;
      if (w == WIDTH_CTRL) begin
         case (i)
            2'd0:    r = ASCII_BACKSLASH;
            2'd1:    r = {6'b001100, b[7:6]};
            2'd2:    r = {5'b00110, b[5:3]};
            default: r = {5'b00110, b[2:0]};
         endcase
      end else if (w == WIDTH_META) begin
         r = (i == 2'd0) ? ASCII_BACKSLASH : b;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sesc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sesc_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, has_byte, in_byte, in_last, input ready);
   modport sink   (input valid, has_byte, in_byte, in_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sesc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sesc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        run_last;
   logic        string_done;
   logic [1:0]  status;
   logic [15:0] encoded_length;
   logic        any_escaped;

   modport source (output valid, out_byte, byte_valid, run_last, string_done, status,
                   encoded_length, any_escaped, input ready);
   modport sink   (input valid, out_byte, byte_valid, run_last, string_done, status,
                   encoded_length, any_escaped, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sesc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sesc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sesc_pkg::cfg_type cfg,
   sesc_req_if.sink               req_if,
   input  wire logic              q_full,
   output logic                   push,
   output sesc_pkg::job_type      job
);

   logic [15:0] count_ff, count_in, count_next;
   logic        esc_ff, esc_in, esc_next;
   logic        ovf_ff, ovf_in, ovf_next;
   logic [2:0]  w;
   logic [16:0] sum;
   logic        too_big, fits, emit, accept;
   logic [1:0]  status;
   logic [15:0] len;

   // Take a word whenever the queue has room
   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   // Classify the byte and work out the new string state
   always_comb begin
      w          = sesc_pkg::byte_width(req_if.in_byte);
      too_big    = {4'b0, cfg.expected_length} >= 17'(sesc_pkg::MAX_OUTPUT);
      sum        = {1'b0, count_ff} + {14'b0, w};
      fits       = sum <= {4'b0, cfg.expected_length};
      count_next = count_ff;
      esc_next   = esc_ff;
      ovf_next   = ovf_ff;
      emit       = 1'b0;
      if (req_if.has_byte) begin
         if (w != sesc_pkg::WIDTH_PLAIN) begin
            esc_next = 1'b1;
         end
         if (cfg.measure_only) begin
            count_next = sum[16] ? sesc_pkg::COUNT_MAX : sum[15:0];
         end else if (!ovf_ff && !too_big) begin
            if (!fits) begin
               ovf_next = 1'b1;
            end else begin
               emit       = 1'b1;
               count_next = sum[15:0];
            end
         end
      end
   end

   // Resolve the end-of-string report
   always_comb begin
      if (cfg.measure_only) begin
         status = sesc_pkg::STATUS_OK;
      end else if (ovf_next || too_big) begin
         status = sesc_pkg::STATUS_CAPACITY;
      end else if (count_next != {3'b0, cfg.expected_length}) begin
         status = sesc_pkg::STATUS_MISMATCH;
      end else begin
         status = sesc_pkg::STATUS_OK;
      end
      len = (cfg.measure_only && !esc_next) ? 16'd0 : count_next;
   end

   // Build the job for the back end
   always_comb begin
      job.byte_val = req_if.in_byte;
      job.width    = w;
      job.emit     = emit;
      job.last_idx = emit ? 2'(w - 3'd1) : 2'd0;
      job.base     = count_ff;
      job.last     = req_if.in_last;
      job.status   = status;
      job.len      = len;
      job.esc      = esc_next;
      push         = accept && (emit || req_if.in_last);
   end

   // Advance string state, clear it at the end of a string
   always_comb begin
      count_in = count_ff;
      esc_in   = esc_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_if.in_last) begin
            count_in = '0;
            esc_in   = 1'b0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_next;
            esc_in   = esc_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         esc_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         esc_ff   <= esc_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sesc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sesc_queue #(
   parameter int DEPTH = sesc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sesc_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output sesc_pkg::job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sesc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sesc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sesc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire sesc_pkg::job_type job,
   output logic                   pop,
   sesc_rsp_if.source             rsp_if
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        byte_valid_ff, byte_valid_in;
   logic        run_last_ff, run_last_in;
   logic        done_ff, done_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] len_ff, len_in;
   logic        esc_ff, esc_in;
   logic        load, final_word;

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.out_byte       = out_byte_ff;
   assign rsp_if.byte_valid     = byte_valid_ff;
   assign rsp_if.run_last       = run_last_ff;
   assign rsp_if.string_done    = done_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.encoded_length = len_ff;
   assign rsp_if.any_escaped    = esc_ff;

   // Load the output register when it is empty or being drained
   assign load       = q_valid && (!valid_ff || rsp_if.ready);
   assign final_word = idx_ff == job.last_idx;
   assign pop        = load && final_word;

   // Form the next word of the head job
   always_comb begin
      out_byte_in   = job.emit ? sesc_pkg::seq_byte(job.byte_val, job.width, idx_ff) : 8'd0;
      byte_valid_in = job.emit;
      run_last_in   = final_word;
      done_in       = final_word && job.last;
      status_in     = done_in ? job.status : sesc_pkg::STATUS_OK;
      len_in        = done_in ? job.len : job.base + {14'b0, idx_ff} + 16'd1;
      esc_in        = job.esc;
   end

   // Step through the job, drop the valid once taken
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_word ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the word payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= out_byte_in;
         byte_valid_ff <= byte_valid_in;
         run_last_ff   <= run_last_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
         len_ff        <= len_in;
         esc_ff        <= esc_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/shell_escape_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake               Carries
// req_if   in   valid/ready             has_byte, in_byte, in_last
// rsp_if   out  valid/ready             out_byte .. any_escaped
// csr_*    in   APB psel/penable/pready measure_only (0x0), expected_length (0x4)
//
// The back end sends one word per cycle unless rsp_if stalls: a control byte
// makes 4 words, a metacharacter 2, any other emitted byte 1, a bare string end 1.
// The front classifies one item per cycle while the queue has room; a job
// queue of QUEUE_DEPTH entries lets it run ahead while the output register is stalled.
// Reset is synchronous and clears string state, queue and output valid.

module shell_escape_encoder_core #(
   parameter int QUEUE_DEPTH = sesc_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   sesc_req_if.sink         req_if,
   sesc_rsp_if.source       rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic              measure_only_ff, measure_only_in;
   logic [12:0]       expected_length_ff, expected_length_in;
   logic              csr_write;
   sesc_pkg::cfg_type cfg;
   sesc_pkg::job_type push_job, head_job;
   logic              push, pop, q_full, q_valid;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      measure_only_in    = measure_only_ff;
      expected_length_in = expected_length_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            sesc_pkg::REG_MEASURE_ONLY:    measure_only_in    = csr_pwdata[0];
            sesc_pkg::REG_EXPECTED_LENGTH: expected_length_in = csr_pwdata[12:0];
            default:                       measure_only_in    = measure_only_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sesc_pkg::REG_MEASURE_ONLY:    csr_prdata = {31'b0, measure_only_ff};
         sesc_pkg::REG_EXPECTED_LENGTH: csr_prdata = {19'b0, expected_length_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_only_ff    <= 1'b0;
         expected_length_ff <= '0;
      end else begin
         measure_only_ff    <= measure_only_in;
         expected_length_ff <= expected_length_in;
      end
   end

   assign cfg.measure_only    = measure_only_ff;
   assign cfg.expected_length = expected_length_ff;

   sesc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   sesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   sesc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .job     (head_job),
      .pop     (pop),
      .rsp_if  (rsp_if)
   );

endmodule

`default_nettype wire

>>> rtl/core/sesc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sesc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        byte_valid,
   input wire logic [7:0]  out_byte,
   input wire logic        run_last,
   input wire logic        string_done,
   input wire logic [1:0]  status
);

   // A stalled word stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Status only reports at the end of a string
   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !string_done |-> status == sesc_pkg::STATUS_OK)
      else $error("status set before string end");

   // The string end closes its item's run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_done |-> run_last)
      else $error("string end without run end");

   // A word without a byte is only the bare end report, with a zero byte
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> string_done && out_byte == 8'd0)
      else $error("empty word outside string end");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind shell_escape_encoder_core sesc_checker u_sesc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .byte_valid  (rsp_if.byte_valid),
   .out_byte    (rsp_if.out_byte),
   .run_last    (rsp_if.run_last),
   .string_done (rsp_if.string_done),
   .status      (rsp_if.status)
);

`default_nettype wire
